### design/bd2x2_pkg.sv
// shared constants, types and helpers of the 2x2 box downsampler
package bd2x2_pkg;

   localparam int MAX_WIDTH    = 4096;
   localparam int MAX_HEIGHT   = 4096;
   localparam int MAX_CHANNELS = 4;
   localparam int LANES        = 4;

   localparam int CH_W  = 8;
   localparam int HS_W  = CH_W + 1;
   localparam int SUM_W = HS_W + 1;
   localparam int REG_W = 13;
   localparam int NC_W  = 3;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int EW_W       = COL_W + 1;
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int EH_W       = ROW_W + 1;
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int DX_W       = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int DY_W       = (ROW_W > 1) ? ROW_W - 1 : 1;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [1:0] REG_SRC_WIDTH     = 2'd0;
   localparam logic [1:0] REG_SRC_HEIGHT    = 2'd1;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

   // back-end operation codes
   localparam logic [1:0] OP_STORE  = 2'd0;
   localparam logic [1:0] OP_DOUBLE = 2'd1;
   localparam logic [1:0] OP_SUM    = 2'd2;

   typedef struct packed {
      logic [EW_W-1:0] width;
      logic [EH_W-1:0] height;
      logic [NC_W-1:0] nchan;
   } bd2x2_cfg_type;

   typedef struct packed {
      logic [1:0]              op;
      logic                    last;
      logic [DX_W-1:0]         dx;
      logic [LANES*HS_W-1:0]   hs;
   } bd2x2_op_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } bd2x2_qstat_type;

   function automatic logic [EW_W-1:0] clamp_width(logic [REG_W-1:0] v);
      if (v == '0) begin
         return EW_W'(1);
      end else if (int'(v) > MAX_WIDTH) begin
         return EW_W'(MAX_WIDTH);
      end else begin
         return EW_W'(v);
      end
   endfunction

   function automatic logic [EH_W-1:0] clamp_height(logic [REG_W-1:0] v);
      if (v == '0) begin
         return EH_W'(1);
      end else if (int'(v) > MAX_HEIGHT) begin
         return EH_W'(MAX_HEIGHT);
      end else begin
         return EH_W'(v);
      end
   endfunction

   function automatic logic [NC_W-1:0] clamp_nchan(logic [NC_W-1:0] v);
      if (v == '0) begin
         return NC_W'(1);
      end else if (int'(v) > MAX_CHANNELS) begin
         return NC_W'(MAX_CHANNELS);
      end else begin
         return v;
      end
   endfunction

endpackage

### design/bd2x2_req_if.sv
// source texel channel: valid, ready and four channel bytes
interface bd2x2_req_if import bd2x2_pkg::*; ;
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] in_ch0;
   logic [CH_W-1:0] in_ch1;
   logic [CH_W-1:0] in_ch2;
   logic [CH_W-1:0] in_ch3;

   modport source (output valid, output in_ch0, output in_ch1, output in_ch2,
                   output in_ch3, input ready);
   modport sink (input valid, input in_ch0, input in_ch1, input in_ch2,
                 input in_ch3, output ready);
endinterface

### design/bd2x2_rsp_if.sv
// destination texel channel: valid, ready, four averaged bytes and end mark
interface bd2x2_rsp_if import bd2x2_pkg::*; ;
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] out_ch0;
   logic [CH_W-1:0] out_ch1;
   logic [CH_W-1:0] out_ch2;
   logic [CH_W-1:0] out_ch3;
   logic            last_of_level;

   modport source (output valid, output out_ch0, output out_ch1, output out_ch2,
                   output out_ch3, output last_of_level, input ready);
   modport sink (input valid, input out_ch0, input out_ch1, input out_ch2,
                 input out_ch3, input last_of_level, output ready);
endinterface

### design/bd2x2_front.sv
// front end: raster counters, horizontal pairing and operation classification
module bd2x2_front import bd2x2_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  bd2x2_cfg_type         cfg,
   input  logic                  accept,
   input  logic [LANES*CH_W-1:0] texel,
   output logic                  push,
   output bd2x2_op_type          op_out
);

   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [LANES*CH_W-1:0] hold_ff, hold_in;

   logic [EW_W-1:0] dw;
   logic [EH_W-1:0] dh;
   logic            col_last, row_last;
   logic            have_pair, row_ok;
   logic [1:0]      op_code;
   logic [DX_W-1:0] dx;
   logic [DY_W-1:0] dy;
   logic [LANES*HS_W-1:0] hs;

   assign dw = (cfg.width  >> 1) != '0 ? (cfg.width  >> 1) : EW_W'(1);
   assign dh = (cfg.height >> 1) != '0 ? (cfg.height >> 1) : EH_W'(1);

   assign col_last = (EW_W'(col_ff) == cfg.width  - EW_W'(1));
   assign row_last = (EH_W'(row_ff) == cfg.height - EH_W'(1));

   always_comb begin
      have_pair = 1'b0;
      dx        = '0;
      hs        = '0;
      hold_in   = hold_ff;
      if (cfg.width == EW_W'(1)) begin
         have_pair = 1'b1;
         for (int i = 0; i < LANES; i++) begin
            hs[i*HS_W +: HS_W] = {texel[i*CH_W +: CH_W], 1'b0};
         end
      end else if (EW_W'(col_ff) < {cfg.width[EW_W-1:1], 1'b0}) begin
         if (!col_ff[0]) begin
            hold_in = texel;
         end else begin
            have_pair = 1'b1;
            dx        = DX_W'(col_ff >> 1);
            for (int i = 0; i < LANES; i++) begin
               hs[i*HS_W +: HS_W] = HS_W'(hold_ff[i*CH_W +: CH_W])
                                  + HS_W'(texel[i*CH_W +: CH_W]);
            end
         end
      end
   end

   // vertical classification: single row doubles, even row stores, odd row sums
   always_comb begin
      row_ok  = 1'b0;
      op_code = OP_STORE;
      if (cfg.height == EH_W'(1)) begin
         row_ok  = 1'b1;
         op_code = OP_DOUBLE;
      end else if (EH_W'(row_ff) < {cfg.height[EH_W-1:1], 1'b0}) begin
         row_ok  = 1'b1;
         op_code = row_ff[0] ? OP_SUM : OP_STORE;
      end
   end

   assign dy   = (cfg.height == EH_W'(1)) ? '0 : DY_W'(row_ff >> 1);
   assign push = accept && have_pair && row_ok;

   always_comb begin
      op_out.op   = op_code;
      op_out.dx   = dx;
      op_out.hs   = hs;
      op_out.last = (dx == DX_W'(dw - EW_W'(1))) && (dy == DY_W'(dh - EH_W'(1)));
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff  <= '0;
         row_ff  <= '0;
         hold_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            hold_ff <= hold_in;
         end
      end
   end

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      EW_W'(col_ff) < cfg.width && EH_W'(row_ff) < cfg.height)
      else $error("raster counters left the level");

   a_level_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && !restart && col_last && row_last |=> col_ff == '0 && row_ff == '0)
      else $error("counters did not wrap at end of level");

endmodule

### design/bd2x2_queue.sv
// short queue of operations between front and back end
module bd2x2_queue import bd2x2_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  bd2x2_op_type    push_op,
   input  logic            pop,
   output bd2x2_op_type    head_op,
   output bd2x2_qstat_type stat
);

   bd2x2_op_type       entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_PTR_W:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign stat.full      = (count_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign stat.not_empty = (count_ff != '0);
   assign do_push        = push && !stat.full;
   assign do_pop         = pop && stat.not_empty;
   assign head_op        = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (Q_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (Q_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + (Q_PTR_W+1)'(1))
      else $error("queue fill count lost a push");

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (Q_PTR_W+1)'(Q_DEPTH))
      else $error("queue overfilled");

endmodule

### design/bd2x2_back.sv
// back end: line buffer, vertical sum, rounding and output register
module bd2x2_back import bd2x2_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  bd2x2_cfg_type        cfg,
   input  bd2x2_op_type         head_op,
   input  bd2x2_qstat_type      stat,
   output logic                 pop,
   bd2x2_rsp_if.source          rsp_chan
);

   logic [LANES*HS_W-1:0] line_mem [LINE_DEPTH];
   logic [LANES*HS_W-1:0] rd_ff;

   logic                  s1_valid_ff, s1_valid_in;
   logic [1:0]            s1_op_ff;
   logic [LANES*HS_W-1:0] s1_hs_ff;
   logic                  s1_last_ff;

   logic                  out_valid_ff, out_valid_in;
   logic [LANES*CH_W-1:0] out_data_ff, out_data_in;
   logic                  out_last_ff;

   logic out_free, s1_free, s1_adv, pop_calc, pop_store;
   logic [SUM_W-1:0] sum;
   logic [SUM_W:0]   rounded;

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign s1_free   = !s1_valid_ff || out_free;
   // stores never touch stage one, so they drain even while output stalls
   assign pop       = stat.not_empty && (s1_free || head_op.op == OP_STORE);
   assign pop_store = pop && head_op.op == OP_STORE;
   assign pop_calc  = pop && head_op.op != OP_STORE;

   always_ff @(posedge clock) begin
      if (pop_store) begin
         line_mem[head_op.dx] <= head_op.hs;
      end
      if (pop && head_op.op == OP_SUM) begin
         rd_ff <= line_mem[head_op.dx];
      end
   end

   assign s1_valid_in = pop_calc || (s1_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (pop_calc) begin
         s1_op_ff   <= head_op.op;
         s1_hs_ff   <= head_op.hs;
         s1_last_ff <= head_op.last;
      end
   end

   always_comb begin
      out_data_in = '0;
      sum         = '0;
      rounded     = '0;
      for (int i = 0; i < LANES; i++) begin
         unique case (s1_op_ff)
            OP_DOUBLE: sum = {s1_hs_ff[i*HS_W +: HS_W], 1'b0};
            OP_SUM:    sum = SUM_W'(rd_ff[i*HS_W +: HS_W])
                           + SUM_W'(s1_hs_ff[i*HS_W +: HS_W]);
            default:   sum = '0;
         endcase
         rounded = (SUM_W+1)'(sum) + (SUM_W+1)'(2);
         if (NC_W'(i) < cfg.nchan) begin
            out_data_in[i*CH_W +: CH_W] = CH_W'(rounded >> 2);
         end
      end
   end

   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_data_ff <= out_data_in;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.out_ch0       = out_data_ff[0*CH_W +: CH_W];
   assign rsp_chan.out_ch1       = out_data_ff[1*CH_W +: CH_W];
   assign rsp_chan.out_ch2       = out_data_ff[2*CH_W +: CH_W];
   assign rsp_chan.out_ch3       = out_data_ff[3*CH_W +: CH_W];
   assign rsp_chan.last_of_level = out_last_ff;

   a_sum_enters_stage: assert property (@(posedge clock) disable iff (reset)
      pop && head_op.op == OP_SUM |=> s1_valid_ff && s1_op_ff == OP_SUM)
      else $error("summing op did not reach stage one");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_hs_ff))
      else $error("stage one lost a word under back-pressure");

endmodule

### design/box_downsample_2x2_bytes_top.sv
// top level of the 2x2 box-filter mip downsampler with its register port
// Takes source texels of one mip level in raster order, one word per clock
// while the queue is not full, and returns one averaged destination texel
// per 2x2 source block, each channel rounded as (sum+2)>>2, with
// last_of_level set on the final texel of the level. Destination extent is
// max(1, source/2); a source extent of 1 counts each texel twice, and at odd
// extents the last column or row is dropped. Sustained rate is one source
// texel per clock while the output is not back-pressured: the front end
// classifies a texel in the cycle it is taken, a four-entry queue carries the
// resulting line-buffer operation to the back end, and the back end does one
// line-buffer access (write of an even-row pair sum or read for an odd-row
// sum) per clock on a 2048 x 36-bit single-port memory. A result passes the
// queue, then stage one, then the output register before rsp_chan valid rises.
// The line buffer needs no clearing after reset. Registers:
// 0x0 src_width, 0x4 src_height, 0x8 channel_count; writing any of them
// restarts the level and must be done only while no word is in flight.
module box_downsample_2x2_bytes_top import bd2x2_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bd2x2_req_if.sink             req_chan,
   bd2x2_rsp_if.source           rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // raw register values as written, for read-back
   logic [REG_W-1:0] width_reg_ff;
   logic [REG_W-1:0] height_reg_ff;
   logic [NC_W-1:0]  nchan_reg_ff;
   // clamped working copy used by the datapath
   bd2x2_cfg_type    cfg_ff;

   logic       csr_wr;
   logic [1:0] csr_idx;
   logic       restart;

   logic            accept;
   logic            push;
   logic            pop;
   bd2x2_op_type    front_op;
   bd2x2_op_type    head_op;
   bd2x2_qstat_type qstat;

   // register port: always ready, word index from the upper address bits
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];

   always_comb begin
      restart = 1'b0;
      unique case (csr_idx)
         REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_CHANNEL_COUNT: restart = csr_wr;
         default: restart = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= REG_W'(1);
         height_reg_ff <= REG_W'(1);
         nchan_reg_ff  <= NC_W'(MAX_CHANNELS);
         cfg_ff.width  <= EW_W'(1);
         cfg_ff.height <= EH_W'(1);
         cfg_ff.nchan  <= NC_W'(MAX_CHANNELS);
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_SRC_WIDTH: begin
               width_reg_ff <= pwdata[REG_W-1:0];
               cfg_ff.width <= clamp_width(pwdata[REG_W-1:0]);
            end
            REG_SRC_HEIGHT: begin
               height_reg_ff <= pwdata[REG_W-1:0];
               cfg_ff.height <= clamp_height(pwdata[REG_W-1:0]);
            end
            REG_CHANNEL_COUNT: begin
               nchan_reg_ff <= pwdata[NC_W-1:0];
               cfg_ff.nchan <= clamp_nchan(pwdata[NC_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SRC_WIDTH:     prdata = CSR_DATA_W'(width_reg_ff);
         REG_SRC_HEIGHT:    prdata = CSR_DATA_W'(height_reg_ff);
         REG_CHANNEL_COUNT: prdata = CSR_DATA_W'(nchan_reg_ff);
         default:           prdata = '0;
      endcase
   end

   // input side only waits on queue space, never on the output side
   assign req_chan.ready = !qstat.full;
   assign accept         = req_chan.valid && req_chan.ready;

   bd2x2_front u_front (
      .clock   (clock),
      .reset   (reset),
      .restart (restart),
      .cfg     (cfg_ff),
      .accept  (accept),
      .texel   ({req_chan.in_ch3, req_chan.in_ch2, req_chan.in_ch1, req_chan.in_ch0}),
      .push    (push),
      .op_out  (front_op)
   );

   bd2x2_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (front_op),
      .pop     (pop),
      .head_op (head_op),
      .stat    (qstat)
   );

   bd2x2_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head_op  (head_op),
      .stat     (qstat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
